>>> rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> rtl/zsa_pkg.sv
`timescale 1ns / 1ps
package zsa_pkg;
  localparam int unsigned Zones = 256;
  localparam int unsigned ZoneW = $clog2(Zones);
  localparam int unsigned AccW = 48;
  localparam int unsigned CntW = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 3;

  localparam logic [1:0] OpAccum = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [2:0] ModeSum   = 3'd0;
  localparam logic [2:0] ModeMean  = 3'd1;
  localparam logic [2:0] ModeMin   = 3'd2;
  localparam logic [2:0] ModeMax   = 3'd3;
  localparam logic [2:0] ModeIsNa  = 3'd4;
  localparam logic [2:0] ModeNotNa = 3'd5;

  localparam logic [CfgIdxW-1:0] RegStatMode    = 1'd0;
  localparam logic [CfgIdxW-1:0] RegDropMissing = 1'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  zone_index;
    logic        zone_missing;
    logic signed [31:0] sample_value;
    logic        sample_missing;
  } item_in_t;

  typedef struct packed {
    logic [7:0]  result_zone;
    logic signed [47:0] stat_value;
    logic [31:0] pixel_count;
    logic        zone_seen;
    logic        result_missing;
  } item_out_t;

  // One zone entry of the statistics store.
  typedef struct packed {
    logic signed [AccW-1:0] accum;
    logic [CntW-1:0] count;
    logic seen;
    logic poisoned;
  } zone_entry_t;

  // Request handed from the control path to the divider.
  typedef struct packed {
    logic start;
    logic signed [AccW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;
endpackage

>>> rtl/zsa_divider.sv
`timescale 1ns / 1ps
module zsa_divider import zsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  div_req_t req_i,
  output logic done_o,
  output logic signed [AccW-1:0] quot_o
);
  localparam int unsigned StepW = $clog2(AccW + 1);

  logic [AccW-1:0] rem_q, rem_d, quo_q, quo_d, mag_q, mag_d;
  logic [CntW-1:0] dvs_q, dvs_d;
  logic neg_q, neg_d;
  logic [StepW-1:0] step_q, step_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [AccW:0] shifted;
  logic [AccW:0] diff;

  // Restoring division of magnitudes, one quotient bit per cycle.
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; mag_d = mag_q; dvs_d = dvs_q; neg_d = neg_q;
    step_d = step_q; busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q, mag_q[AccW-1]};
    diff = shifted - {{(AccW+1-CntW){1'b0}}, dvs_q};
    if (req_i.start) begin
      mag_d = req_i.dividend[AccW-1] ? AccW'(-req_i.dividend) : AccW'(req_i.dividend);
      neg_d = req_i.dividend[AccW-1];
      dvs_d = req_i.divisor;
      rem_d = '0; quo_d = '0;
      step_d = StepW'(AccW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[AccW-2:0], 1'b0};
      if (!diff[AccW]) begin
        rem_d = diff[AccW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b1};
      end else begin
        rem_d = shifted[AccW-1:0];
        quo_d = {quo_q[AccW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; mag_q <= mag_d; dvs_q <= dvs_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

>>> rtl/zsa_store.sv
`timescale 1ns / 1ps
module zsa_store import zsa_pkg::*; (
  input  logic clk_i,
  input  logic we_i,
  input  logic [ZoneW-1:0] waddr_i,
  input  zone_entry_t wdata_i,
  input  logic [ZoneW-1:0] raddr_i,
  output zone_entry_t rdata_o
);
  zone_entry_t mem [Zones];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/zonal_statistics_accumulator.sv
`timescale 1ns / 1ps
// Per-zone statistics accumulator.
// Items enter on start/item_i and are taken when start is high and busy
// is low. Op accumulate folds a Q16.16 sample into one zone, op clear resets
// one zone, op read returns one result on result_o with result_valid_o high
// for one cycle; the receiver cannot stall it.
// Each zone lives in a 256-entry synchronous memory with a registered read
// port. Accumulate and clear go through a read, then a modify and write back,
// and busy stays high until the write is done. The result strobe of a read is
// registered, and the next item can be taken while the strobe is high. In
// mean mode a radix-2 divider produces one quotient bit per cycle, and busy
// stays high through the execute, divide and output states until the strobe
// rises. After reset the block sweeps the memory clearing one entry per
// cycle; busy stays high during the sweep. Configuration writes on cfg_we_i,
// cfg_index_i and cfg_data_i are taken at any time and also act on an item
// in flight.
`include "assert_macros.svh"
module zonal_statistics_accumulator import zsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  item_in_t item_i,
  output logic result_valid_o,
  output item_out_t result_o,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  typedef enum logic [4:0] {
    StInit  = 5'b00001,
    StIdle  = 5'b00010,
    StExec  = 5'b00100,
    StDiv   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] mode_q;
  logic drop_q;
  logic [ZoneW:0] init_q;
  item_in_t it_q;
  zone_entry_t rd, wdata;
  logic we;
  logic [ZoneW-1:0] waddr;
  logic [CntW-1:0] cnt_inc;
  logic signed [AccW:0] sum;
  logic signed [AccW-1:0] sv;
  item_out_t res_q, res_d;
  logic rv_q, rv_d;
  logic rd_miss;
  div_req_t dreq;
  logic ddone;
  logic signed [AccW-1:0] dquot;

  zsa_store u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(item_i.zone_index), .rdata_o(rd)
  );

  zsa_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));

  assign busy = (state_q != StIdle);
  assign sv = AccW'(it_q.sample_value);
  assign sum = {rd.accum[AccW-1], rd.accum} + {sv[AccW-1], sv};
  assign cnt_inc = (rd.count == '1) ? rd.count : rd.count + 1'b1;
  assign rd_miss = !rd.seen || rd.poisoned || (rd.count == '0);

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    waddr = it_q.zone_index;
    wdata = rd;
    rv_d = 1'b0;
    res_d = res_q;
    dreq = '{start: 1'b0, dividend: rd.accum, divisor: rd.count};
    unique case (state_q)
      StInit: begin
        we = 1'b1;
        waddr = init_q[ZoneW-1:0];
        wdata = '0;
        if (init_q == (ZoneW+1)'(Zones - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (start && (item_i.op == OpAccum || item_i.op == OpRead || item_i.op == OpClear)) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
        if (it_q.op == OpClear) begin
          we = 1'b1;
          wdata = '0;
        end else if (it_q.op == OpAccum) begin
          if (!it_q.zone_missing && mode_q <= ModeNotNa) begin
            we = 1'b1;
            wdata.seen = 1'b1;
            if (mode_q == ModeIsNa) begin
              if (it_q.sample_missing) wdata.count = cnt_inc;
            end else if (mode_q == ModeNotNa) begin
              if (!it_q.sample_missing) wdata.count = cnt_inc;
            end else if (it_q.sample_missing) begin
              if (!drop_q) wdata.poisoned = 1'b1;
            end else begin
              wdata.count = cnt_inc;
              if (mode_q == ModeSum || mode_q == ModeMean) begin
                if (sum[AccW] != sum[AccW-1]) begin
                  wdata.accum = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}}
                                          : {1'b0, {(AccW-1){1'b1}}};
                end else begin
                  wdata.accum = sum[AccW-1:0];
                end
              end else if (rd.count == '0) begin
                wdata.accum = sv;
              end else if (mode_q == ModeMin) begin
                if (sv < rd.accum) wdata.accum = sv;
              end else if (sv > rd.accum) begin
                wdata.accum = sv;
              end
            end
          end
        end else begin
          res_d.result_zone = it_q.zone_index;
          res_d.pixel_count = rd.count;
          res_d.zone_seen = rd.seen;
          res_d.stat_value = '0;
          res_d.result_missing = 1'b1;
          if (mode_q == ModeIsNa || mode_q == ModeNotNa) begin
            if (rd.seen) begin
              res_d.stat_value = AccW'(rd.count);
              res_d.result_missing = 1'b0;
            end
            rv_d = 1'b1;
          end else if (mode_q <= ModeMax && !rd_miss) begin
            res_d.result_missing = 1'b0;
            if (mode_q == ModeMean) begin
              dreq.start = 1'b1;
              state_d = StDiv;
            end else begin
              res_d.stat_value = rd.accum;
              rv_d = 1'b1;
            end
          end else begin
            rv_d = 1'b1;
          end
        end
      end
      StDiv: begin
        if (ddone) begin
          res_d.stat_value = dquot;
          state_d = StOut;
        end
      end
      StOut: begin
        rv_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      init_q <= '0;
      mode_q <= ModeSum;
      drop_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q <= rv_d;
      if (state_q == StInit) init_q <= init_q + 1'b1;
      if (cfg_we_i) begin
        if (cfg_index_i == RegStatMode) mode_q <= cfg_data_i;
        else if (cfg_index_i == RegDropMissing) drop_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) it_q <= item_i;
    res_q <= res_d;
  end

  assign result_valid_o = rv_q;
  assign result_o = res_q;

  `ASSERT_IMPL(a_div_only_mean, clk_i, rst_ni,
    (state_q == StDiv) |-> (mode_q == ModeMean), "divider used outside mean mode")
  `ASSERT_IMPL(a_no_write_idle, clk_i, rst_ni,
    (state_q == StIdle) |-> !we, "store written while idle")
  `ASSERT_IMPL(a_result_after_work, clk_i, rst_ni,
    result_valid_o |-> ($past(state_q) == StExec || $past(state_q) == StOut),
    "result without a read item")
endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench import zsa_pkg::*; ();

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  item_in_t item_i = '0;
  logic result_valid_o;
  item_out_t result_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  zonal_statistics_accumulator i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .item_i,
    .result_valid_o,
    .result_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted zone store and configuration.
  logic signed [AccW-1:0] zone_sum_q [Zones];
  logic [CntW-1:0] zone_cnt_q [Zones];
  bit zone_seen_q [Zones];
  bit zone_poison_q [Zones];
  logic [2:0] mode_q;
  bit drop_q;

  item_out_t pending_reads[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit allow_gaps = 1'b1;

  localparam logic signed [63:0] SumMax = 64'sd140737488355327;
  localparam logic signed [63:0] SumMin = -64'sd140737488355328;

  function automatic void bump_count(int z);
    if (zone_cnt_q[z] != '1) zone_cnt_q[z]++;
  endfunction

  // Updates the predicted store for one accepted item and queues its result.
  function automatic void predict_item(item_in_t it);
    int z;
    logic signed [63:0] v;
    logic signed [63:0] wide;
    item_out_t r;
    z = it.zone_index;
    v = it.sample_value;
    case (it.op)
      OpAccum: begin
        if (!it.zone_missing && mode_q <= ModeNotNa) begin
          zone_seen_q[z] = 1'b1;
          if (mode_q == ModeIsNa) begin
            if (it.sample_missing) bump_count(z);
          end else if (mode_q == ModeNotNa) begin
            if (!it.sample_missing) bump_count(z);
          end else if (it.sample_missing) begin
            if (!drop_q) zone_poison_q[z] = 1'b1;
          end else begin
            if (mode_q == ModeSum || mode_q == ModeMean) begin
              wide = 64'(zone_sum_q[z]) + v;
              if (wide > SumMax) wide = SumMax;
              if (wide < SumMin) wide = SumMin;
              zone_sum_q[z] = wide[AccW-1:0];
            end else if (zone_cnt_q[z] == 0) begin
              zone_sum_q[z] = v[AccW-1:0];
            end else if (mode_q == ModeMin) begin
              if (v < 64'(zone_sum_q[z])) zone_sum_q[z] = v[AccW-1:0];
            end else begin
              if (v > 64'(zone_sum_q[z])) zone_sum_q[z] = v[AccW-1:0];
            end
            bump_count(z);
          end
        end
      end
      OpClear: begin
        zone_sum_q[z] = '0;
        zone_cnt_q[z] = '0;
        zone_seen_q[z] = 1'b0;
        zone_poison_q[z] = 1'b0;
      end
      OpRead: begin
        r.result_zone = it.zone_index;
        r.stat_value = '0;
        r.pixel_count = zone_cnt_q[z];
        r.zone_seen = zone_seen_q[z];
        r.result_missing = 1'b1;
        if (mode_q == ModeIsNa || mode_q == ModeNotNa) begin
          if (zone_seen_q[z]) begin
            r.stat_value = 48'(zone_cnt_q[z]);
            r.result_missing = 1'b0;
          end
        end else if (mode_q <= ModeMax) begin
          if (zone_seen_q[z] && !zone_poison_q[z] && zone_cnt_q[z] != 0) begin
            r.result_missing = 1'b0;
            if (mode_q == ModeMean) begin
              wide = 64'(zone_sum_q[z]) / $signed({32'd0, zone_cnt_q[z]});
              r.stat_value = wide[AccW-1:0];
            end else begin
              r.stat_value = zone_sum_q[z];
            end
          end
        end
        pending_reads = {pending_reads, r};
      end
      default: ;
    endcase
  endfunction

  // Outputs are sampled at the edge that ends the strobe cycle.
  always @(posedge clk_i) begin
    item_out_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result for zone %0d", result_o.result_zone);
        fail_count++;
      end else begin
        e = pending_reads.pop_front();
        if (result_o.result_zone !== e.result_zone) begin
          $error("result_zone: expected %0d, got %0d", e.result_zone, result_o.result_zone);
          fail_count++;
        end
        if (result_o.stat_value !== e.stat_value) begin
          $error("stat_value: expected %0d, got %0d", e.stat_value, result_o.stat_value);
          fail_count++;
        end
        if (result_o.pixel_count !== e.pixel_count) begin
          $error("pixel_count: expected %0d, got %0d", e.pixel_count, result_o.pixel_count);
          fail_count++;
        end
        if (result_o.zone_seen !== e.zone_seen) begin
          $error("zone_seen: expected %0d, got %0d", e.zone_seen, result_o.zone_seen);
          fail_count++;
        end
        if (result_o.result_missing !== e.result_missing) begin
          $error("result_missing: expected %0d, got %0d", e.result_missing,
                 result_o.result_missing);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Drives one item and returns at the edge where it is taken.
  task automatic send_item(item_in_t it);
    int unsigned gap;
    @(negedge clk_i);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predict_item(it);
  endtask

  task automatic send(logic [1:0] op, int zone, logic signed [31:0] value,
                      bit smiss = 1'b0, bit zmiss = 1'b0);
    item_in_t it;
    it.op = op;
    it.zone_index = zone[7:0];
    it.zone_missing = zmiss;
    it.sample_value = value;
    it.sample_missing = smiss;
    send_item(it);
  endtask

  // Waits until the block has nothing left in flight.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_config(logic [2:0] mode, bit drop);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= RegStatMode;
    cfg_data_i <= mode;
    @(negedge clk_i);
    cfg_index_i <= RegDropMissing;
    cfg_data_i <= CfgDataW'(drop);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = mode;
    drop_q = drop;
  endtask

  task automatic test_directed();
    logic [2:0] modes [8] = '{ModeSum, ModeMean, ModeMin, ModeMax, ModeIsNa, ModeNotNa,
                              3'd6, 3'd7};
    foreach (modes[m]) begin
      set_config(modes[m], m[0]);
      send(OpClear, 0, 0);
      send(OpClear, 255, 0);
      send(OpRead, 0, 0);
      send(OpAccum, 0, 32'sh7fffffff);
      send(OpAccum, 0, 32'sh80000000);
      send(OpAccum, 0, -32'sd3);
      send(OpAccum, 0, 32'sd5, 1'b1);
      send(OpAccum, 0, 32'sd99, 1'b0, 1'b1);
      send(OpUnused, 0, 32'sd7);
      send(OpAccum, 255, 32'sh00010000);
      send(OpAccum, 255, 32'sd0, 1'b1);
      send(OpRead, 0, 0);
      send(OpRead, 255, 0);
    end
    // A later mode reads what an earlier mode stored in zone 0.
    set_config(ModeMean, 1'b0);
    send(OpRead, 0, 0);
    send(OpClear, 0, 0);
    send(OpRead, 0, 0);
  endtask

  // Builds large sums of both signs and divides them in mean mode.
  task automatic test_large_sums();
    set_config(ModeSum, 1'b1);
    allow_gaps = 1'b0;
    send(OpClear, 3, 0);
    send(OpClear, 4, 0);
    for (int i = 0; i < 20; i++) begin
      send(OpAccum, 3, 32'sh7fffffff);
      send(OpAccum, 4, 32'sh80000000);
    end
    send(OpRead, 3, 0);
    send(OpRead, 4, 0);
    send(OpAccum, 3, -32'sd1);
    send(OpRead, 3, 0);
    allow_gaps = 1'b1;
    set_config(ModeMean, 1'b1);
    send(OpRead, 3, 0);
    send(OpRead, 4, 0);
  endtask

  task automatic test_random();
    int unsigned sel;
    int zone;
    logic signed [31:0] value;
    for (int phase = 0; phase < 8; phase++) begin
      set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      // The last phase runs back to back.
      if (phase == 7) allow_gaps = 1'b0;
      for (int n = 0; n < 100; n++) begin
        sel = $urandom_range(0, 99);
        zone = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
        case ($urandom_range(0, 4))
          0: value = 32'sh7fffffff;
          1: value = 32'sh80000000;
          2: value = $signed(32'($urandom_range(0, 200))) - 32'sd100;
          default: value = $urandom;
        endcase
        if (sel < 68) begin
          send(OpAccum, zone, value, $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
        end else if (sel < 90) begin
          send(OpRead, zone, value);
        end else if (sel < 97) begin
          send(OpClear, zone, value);
        end else begin
          send(OpUnused, zone, value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    for (int z = 0; z < Zones; z++) begin
      zone_sum_q[z] = '0;
      zone_cnt_q[z] = '0;
      zone_seen_q[z] = 1'b0;
      zone_poison_q[z] = 1'b0;
    end
    mode_q = ModeSum;
    drop_q = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_large_sums();
    test_random();
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
